### hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the blend unit RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define VOBB_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define VOBB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hdl/vobb_pkg.sv
// ---------------------------------------------------------------------------
// vobb_pkg
// Shared widths, register codes and config record of the blend unit.
// ---------------------------------------------------------------------------
package vobb_pkg;

    localparam int REG_W         = 13;
    localparam int CFG_IDX_W     = 3;
    localparam int BYTE_W        = 8;
    localparam int VOL_W         = 17;
    localparam int IDX_W         = 24;
    localparam int DEF_MAX_DIM   = 4096;
    localparam int DEF_FRAC_BITS = 16;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCREEN_WIDTH  = 3'd0,
        REG_SCREEN_HEIGHT = 3'd1,
        REG_BOX_X_MIN     = 3'd2,
        REG_BOX_X_MAX     = 3'd3,
        REG_BOX_Y_MIN     = 3'd4,
        REG_BOX_Y_MAX     = 3'd5,
        REG_VOLUME_WIDTH  = 3'd6
    } cfg_reg_t;

    // Configuration register file contents
    typedef struct packed {
        logic [REG_W-1:0] screen_width;
        logic [REG_W-1:0] screen_height;
        logic [REG_W-1:0] box_x_min;
        logic [REG_W-1:0] box_x_max;
        logic [REG_W-1:0] box_y_min;
        logic [REG_W-1:0] box_y_max;
        logic [REG_W-1:0] volume_width;
    } cfg_t;

endpackage

### hdl/vobb_pixel_if.sv
// ---------------------------------------------------------------------------
// vobb_pixel_if
// Input pixel channel: background RGB bytes and premultiplied volume RGBA.
// ---------------------------------------------------------------------------
interface vobb_pixel_if;
    import vobb_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] bg_red;
    logic [BYTE_W-1:0] bg_green;
    logic [BYTE_W-1:0] bg_blue;
    logic [VOL_W-1:0]  vol_red;
    logic [VOL_W-1:0]  vol_green;
    logic [VOL_W-1:0]  vol_blue;
    logic [VOL_W-1:0]  vol_alpha;

    modport source (
        output valid, bg_red, bg_green, bg_blue,
               vol_red, vol_green, vol_blue, vol_alpha,
        input  ready
    );

    modport sink (
        input  valid, bg_red, bg_green, bg_blue,
               vol_red, vol_green, vol_blue, vol_alpha,
        output ready
    );
endinterface

### hdl/vobb_result_if.sv
// ---------------------------------------------------------------------------
// vobb_result_if
// Output channel: composited colour bytes, box flag, image index, frame end.
// ---------------------------------------------------------------------------
interface vobb_result_if;
    import vobb_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_red;
    logic [BYTE_W-1:0] out_green;
    logic [BYTE_W-1:0] out_blue;
    logic              inside_box;
    logic [IDX_W-1:0]  volume_index;
    logic              last_of_frame;

    modport source (
        output valid, out_red, out_green, out_blue,
               inside_box, volume_index, last_of_frame,
        input  ready
    );

    modport sink (
        input  valid, out_red, out_green, out_blue,
               inside_box, volume_index, last_of_frame,
        output ready
    );
endinterface

### hdl/volume_over_background_blend_unit.sv
// Pipeline: a pixel taken into the input register moves on to the result register.
// Throughput: one pixel per cycle; with the result stalled the input register
// takes one more pixel, then the input stalls until the result is taken.
// Reset: counters restart at column 0, row 0; both stages empty; config
// registers return to width/height/pitch 1 and an empty box.
// ---------------------------------------------------------------------------
// volume_over_background_blend_unit
// Composites a premultiplied volume sample over the background per pixel.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module volume_over_background_blend_unit #(
    parameter int MAX_DIM   = vobb_pkg::DEF_MAX_DIM,
    parameter int FRAC_BITS = vobb_pkg::DEF_FRAC_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [vobb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vobb_pkg::REG_W-1:0]     cfg_data,
    vobb_pixel_if.sink                     pixel,
    vobb_result_if.source                  result
);
    import vobb_pkg::*;

    localparam int CNT_W  = $clog2(MAX_DIM);
    localparam int CMP_W  = (CNT_W + 1 > REG_W) ? CNT_W + 1 : REG_W;
    localparam int PROD_W = CNT_W + REG_W;
    localparam int SUM_W  = ((PROD_W > IDX_W) ? PROD_W : IDX_W) + 1;

    // configuration registers
    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_width  <= REG_W'(1);
            cfg_reg.screen_height <= REG_W'(1);
            cfg_reg.box_x_min     <= '0;
            cfg_reg.box_x_max     <= '0;
            cfg_reg.box_y_min     <= '0;
            cfg_reg.box_y_max     <= '0;
            cfg_reg.volume_width  <= REG_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SCREEN_WIDTH:  cfg_reg.screen_width  <= cfg_data;
                REG_SCREEN_HEIGHT: cfg_reg.screen_height <= cfg_data;
                REG_BOX_X_MIN:     cfg_reg.box_x_min     <= cfg_data;
                REG_BOX_X_MAX:     cfg_reg.box_x_max     <= cfg_data;
                REG_BOX_Y_MIN:     cfg_reg.box_y_min     <= cfg_data;
                REG_BOX_Y_MAX:     cfg_reg.box_y_max     <= cfg_data;
                REG_VOLUME_WIDTH:  cfg_reg.volume_width  <= cfg_data;
                default: ;
            endcase
        end
    end

    // handshake between the two stages
    logic s1_valid_reg, s1_valid_next;
    logic res_valid_reg, res_valid_next;
    logic res_ready, s1_ready, accept;

    assign res_ready   = !res_valid_reg || result.ready;
    assign s1_ready    = !s1_valid_reg || res_ready;
    assign accept      = pixel.valid && s1_ready;
    assign pixel.ready = s1_ready;

    always_comb
    begin
        s1_valid_next  = accept ? 1'b1 : (res_ready ? 1'b0 : s1_valid_reg);
        res_valid_next = res_ready ? s1_valid_reg : res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // raster position of the incoming pixel
    logic [CNT_W-1:0] scan_col, scan_row;
    logic             scan_last;

    vobb_scan #(
        .MAX_DIM (MAX_DIM)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .advance (accept),
        .col     (scan_col),
        .row     (scan_row),
        .last    (scan_last)
    );

    // input stage
    logic [BYTE_W-1:0] bg_r_reg, bg_g_reg, bg_b_reg;
    logic [VOL_W-1:0]  vol_r_reg, vol_g_reg, vol_b_reg, vol_a_reg;
    logic [CNT_W-1:0]  col_reg, row_reg;
    logic              last_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bg_r_reg  <= pixel.bg_red;
            bg_g_reg  <= pixel.bg_green;
            bg_b_reg  <= pixel.bg_blue;
            vol_r_reg <= pixel.vol_red;
            vol_g_reg <= pixel.vol_green;
            vol_b_reg <= pixel.vol_blue;
            vol_a_reg <= pixel.vol_alpha;
            col_reg   <= scan_col;
            row_reg   <= scan_row;
            last_reg  <= scan_last;
        end
    end

    // box test and composited image index
    logic              in_box;
    logic              blend_en;
    logic [CMP_W-1:0]  dx_full, dy_full;
    logic [PROD_W-1:0] row_base;
    logic [SUM_W-1:0]  idx_sum;
    logic [IDX_W-1:0]  idx;

    always_comb
    begin
        in_box = (CMP_W'(col_reg) >= CMP_W'(cfg_reg.box_x_min))
              && (CMP_W'(col_reg) <  CMP_W'(cfg_reg.box_x_max))
              && (CMP_W'(row_reg) >= CMP_W'(cfg_reg.box_y_min))
              && (CMP_W'(row_reg) <  CMP_W'(cfg_reg.box_y_max));
        dx_full  = CMP_W'(col_reg) - CMP_W'(cfg_reg.box_x_min);
        dy_full  = CMP_W'(row_reg) - CMP_W'(cfg_reg.box_y_min);
        row_base = PROD_W'(dy_full[CNT_W-1:0]) * PROD_W'(cfg_reg.volume_width);
        idx_sum  = SUM_W'(row_base) + SUM_W'(dx_full[CNT_W-1:0]);
        idx      = in_box ? idx_sum[IDX_W-1:0] : '0;
        blend_en = in_box && (vol_a_reg != '0);
    end

    // per-channel blend
    logic [BYTE_W-1:0] red_c, green_c, blue_c;

    vobb_blend #(.FRAC_BITS (FRAC_BITS)) u_blend_r (
        .enable (blend_en), .bg (bg_r_reg), .vol (vol_r_reg),
        .alpha  (vol_a_reg), .color (red_c)
    );
    vobb_blend #(.FRAC_BITS (FRAC_BITS)) u_blend_g (
        .enable (blend_en), .bg (bg_g_reg), .vol (vol_g_reg),
        .alpha  (vol_a_reg), .color (green_c)
    );
    vobb_blend #(.FRAC_BITS (FRAC_BITS)) u_blend_b (
        .enable (blend_en), .bg (bg_b_reg), .vol (vol_b_reg),
        .alpha  (vol_a_reg), .color (blue_c)
    );

    // result register
    logic [BYTE_W-1:0] out_r_reg, out_g_reg, out_b_reg;
    logic              out_inside_reg, out_last_reg;
    logic [IDX_W-1:0]  out_idx_reg;

    always_ff @(posedge clk)
    begin
        if (res_ready && s1_valid_reg)
        begin
            out_r_reg      <= red_c;
            out_g_reg      <= green_c;
            out_b_reg      <= blue_c;
            out_inside_reg <= in_box;
            out_idx_reg    <= idx;
            out_last_reg   <= last_reg;
        end
    end

    assign result.valid         = res_valid_reg;
    assign result.out_red       = out_r_reg;
    assign result.out_green     = out_g_reg;
    assign result.out_blue      = out_b_reg;
    assign result.inside_box    = out_inside_reg;
    assign result.volume_index  = out_idx_reg;
    assign result.last_of_frame = out_last_reg;

    `VOBB_ASSERT_IMPLIES(a_outside_idx, clk, rst_n, res_valid_reg && !out_inside_reg, out_idx_reg == '0)
    `VOBB_ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_valid_reg && !res_ready, s1_valid_reg)

endmodule

### hdl/vobb_blend.sv
// ---------------------------------------------------------------------------
// vobb_blend
// One colour channel of the over operator: bg*(1-a) + vol*255, clamped.
// ---------------------------------------------------------------------------
module vobb_blend #(
    parameter int FRAC_BITS = vobb_pkg::DEF_FRAC_BITS
) (
    input  logic                        enable,
    input  logic [vobb_pkg::BYTE_W-1:0] bg,
    input  logic [vobb_pkg::VOL_W-1:0]  vol,
    input  logic [vobb_pkg::VOL_W-1:0]  alpha,
    output logic [vobb_pkg::BYTE_W-1:0] color
);
    import vobb_pkg::*;

    // signed width of (1.0 - alpha)
    localparam int ONE_W  = ((FRAC_BITS + 1 > VOL_W) ? FRAC_BITS + 1 : VOL_W) + 1;
    localparam int PROD_W = ONE_W + BYTE_W + 1;
    localparam int VT_W   = VOL_W + BYTE_W;
    localparam int ACC_W  = ((PROD_W > VT_W + 1) ? PROD_W : VT_W + 1) + 1;
    localparam logic [ONE_W-1:0]        ONE = ONE_W'(1) << FRAC_BITS;
    localparam logic signed [ACC_W-1:0] TOP = $signed(ACC_W'(255) << FRAC_BITS);

    logic signed [ONE_W-1:0]  one_minus;
    logic signed [PROD_W-1:0] bg_term;
    logic [VT_W-1:0]          vol_term;
    logic signed [ACC_W-1:0]  acc;

    // blend sum in units of 2^-FRAC_BITS
    always_comb
    begin
        one_minus = $signed(ONE - ONE_W'(alpha));
        bg_term   = PROD_W'($signed({1'b0, bg})) * PROD_W'(one_minus);
        vol_term  = VT_W'(vol) * VT_W'(8'd255);
        acc       = ACC_W'(bg_term) + ACC_W'($signed({1'b0, vol_term}));
    end

    // clamp to 0..255, truncate, or pass the background
    always_comb
    begin
        if (!enable)
        begin
            color = bg;
        end
        else if (acc < 0)
        begin
            color = '0;
        end
        else if (acc > TOP)
        begin
            color = '1;
        end
        else
        begin
            color = acc[FRAC_BITS +: BYTE_W];
        end
    end

endmodule

### hdl/vobb_scan.sv
// ---------------------------------------------------------------------------
// vobb_scan
// Raster column/row counters; gives the position of the pixel being taken.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module vobb_scan #(
    parameter int MAX_DIM = vobb_pkg::DEF_MAX_DIM
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  vobb_pkg::cfg_t               cfg,
    input  logic                         advance,
    output logic [$clog2(MAX_DIM)-1:0]   col,
    output logic [$clog2(MAX_DIM)-1:0]   row,
    output logic                         last
);
    import vobb_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIM);
    localparam int CMP_W = (CNT_W + 1 > REG_W) ? CNT_W + 1 : REG_W;

    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] row_reg, row_next;
    logic [CMP_W-1:0] width_raw, height_raw;
    logic [CMP_W-1:0] width_eff, height_eff;
    logic             row_end;

    // screen size limited to 1..MAX_DIM
    always_comb
    begin
        width_raw  = CMP_W'(cfg.screen_width);
        height_raw = CMP_W'(cfg.screen_height);
        if (width_raw == '0)
            width_eff = CMP_W'(1);
        else if (width_raw > CMP_W'(MAX_DIM))
            width_eff = CMP_W'(MAX_DIM);
        else
            width_eff = width_raw;
        if (height_raw == '0)
            height_eff = CMP_W'(1);
        else if (height_raw > CMP_W'(MAX_DIM))
            height_eff = CMP_W'(MAX_DIM);
        else
            height_eff = height_raw;
    end

    // end of row / frame; counters past a shrunk bound wrap too
    always_comb
    begin
        row_end = (CMP_W'(col_reg) + CMP_W'(1)) >= width_eff;
        last    = row_end && ((CMP_W'(row_reg) + CMP_W'(1)) >= height_eff);
        if (row_end)
        begin
            col_next = '0;
            row_next = last ? '0 : row_reg + 1'b1;
        end
        else
        begin
            col_next = col_reg + 1'b1;
            row_next = row_reg;
        end
    end

    // advance once per pixel transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (advance)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign col = col_reg;
    assign row = row_reg;

    `VOBB_ASSERT_NEXT(a_frame_wrap, clk, rst_n, advance && last, (col_reg == '0) && (row_reg == '0))
    `VOBB_ASSERT_NEXT(a_col_step, clk, rst_n, advance && !row_end, col_reg == $past(col_reg) + 1'b1)

endmodule

### tb/vobb_blend_checker.sv
// ---------------------------------------------------------------------------
// vobb_blend_checker
// Watches the config port and both pixel channels of the blend unit, keeps
// its own copy of the registers and screen counters, predicts every result
// and compares each transfer on the result channel against the oldest one.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module vobb_blend_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [vobb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vobb_pkg::REG_W-1:0]     cfg_data,
    vobb_pixel_if                          pixel,
    vobb_result_if                         result,
    output int                             mismatches,
    output int                             pending,
    output int                             checked,
    output int                             blended
);
    import vobb_pkg::*;

    localparam longint UNIT    = longint'(1) << DEF_FRAC_BITS;
    localparam longint CEILING = longint'(255) << DEF_FRAC_BITS;

    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic              in_box;
        logic [IDX_W-1:0]  index;
        logic              last;
    } pixel_result_t;

    pixel_result_t expected_q[$];
    cfg_t          regs;
    logic [11:0]   column_pos;
    logic [11:0]   row_pos;

    // Screen size as the counters see it: 0 acts as 1, oversize saturates
    function automatic int clamp_dim(input logic [REG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > DEF_MAX_DIM)
            return DEF_MAX_DIM;
        return int'(v);
    endfunction

    // bg * (1 - alpha) + vol * 255, clamped to a byte and truncated
    function automatic logic [BYTE_W-1:0] channel_mix(input logic [BYTE_W-1:0] bg,
                                                      input logic [VOL_W-1:0]  vol,
                                                      input logic [VOL_W-1:0]  alpha);
        longint acc;
        acc = longint'(bg) * (UNIT - longint'(alpha)) + longint'(vol) * 255;
        if (acc < 0)
            acc = 0;
        if (acc > CEILING)
            acc = CEILING;
        return BYTE_W'(acc >>> DEF_FRAC_BITS);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        int            w;
        int            h;
        int            x;
        int            y;
        logic          hit;
        pixel_result_t want;
        pixel_result_t got;
        if (!rst_n)
        begin
            regs              = '0;
            regs.screen_width  = REG_W'(1);
            regs.screen_height = REG_W'(1);
            regs.volume_width  = REG_W'(1);
            column_pos        = '0;
            row_pos           = '0;
            expected_q.delete();
            pending <= 0;
        end
        else
        begin
            // register writes; unknown indexes are dropped
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_SCREEN_WIDTH:  regs.screen_width  = cfg_data;
                    REG_SCREEN_HEIGHT: regs.screen_height = cfg_data;
                    REG_BOX_X_MIN:     regs.box_x_min     = cfg_data;
                    REG_BOX_X_MAX:     regs.box_x_max     = cfg_data;
                    REG_BOX_Y_MIN:     regs.box_y_min     = cfg_data;
                    REG_BOX_Y_MAX:     regs.box_y_max     = cfg_data;
                    REG_VOLUME_WIDTH:  regs.volume_width  = cfg_data;
                    default: ;
                endcase
            end

            // predict the pixel taken on this edge
            if (pixel.valid && pixel.ready)
            begin
                w   = clamp_dim(regs.screen_width);
                h   = clamp_dim(regs.screen_height);
                x   = int'(column_pos);
                y   = int'(row_pos);
                hit = x >= int'(regs.box_x_min) && x < int'(regs.box_x_max) &&
                      y >= int'(regs.box_y_min) && y < int'(regs.box_y_max);
                want.in_box = hit;
                want.last   = (x + 1 >= w) && (y + 1 >= h);
                want.index  = hit ? IDX_W'((y - int'(regs.box_y_min)) * int'(regs.volume_width)
                                           + (x - int'(regs.box_x_min))) : '0;
                if (hit && pixel.vol_alpha != 0)
                begin
                    want.red   = channel_mix(pixel.bg_red, pixel.vol_red, pixel.vol_alpha);
                    want.green = channel_mix(pixel.bg_green, pixel.vol_green, pixel.vol_alpha);
                    want.blue  = channel_mix(pixel.bg_blue, pixel.vol_blue, pixel.vol_alpha);
                    blended++;
                end
                else
                begin
                    want.red   = pixel.bg_red;
                    want.green = pixel.bg_green;
                    want.blue  = pixel.bg_blue;
                end
                expected_q.push_back(want);

                // raster advance; a counter past a shrunk bound wraps too
                if (x + 1 >= w)
                begin
                    column_pos = '0;
                    row_pos    = (y + 1 >= h) ? 12'd0 : 12'(y + 1);
                end
                else
                    column_pos = 12'(x + 1);
            end

            // compare the result taken on this edge
            if (result.valid && result.ready)
            begin
                got.red    = result.out_red;
                got.green  = result.out_green;
                got.blue   = result.out_blue;
                got.in_box = result.inside_box;
                got.index  = result.volume_index;
                got.last   = result.last_of_frame;
                if (expected_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("[%0t] result transfer with nothing pending: rgb %0d %0d %0d",
                                 $realtime, got.red, got.green, got.blue);
                    mismatches++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    checked++;
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue || got.in_box !== want.in_box ||
                        got.index !== want.index || got.last !== want.last)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("[%0t] pixel %0d expected rgb %0d %0d %0d in %0b idx %0d last %0b",
                                     $realtime, checked, want.red, want.green, want.blue,
                                     want.in_box, want.index, want.last);
                            $display("        got      rgb %0d %0d %0d in %0b idx %0d last %0b",
                                     got.red, got.green, got.blue,
                                     got.in_box, got.index, got.last);
                        end
                        mismatches++;
                    end
                end
            end
            pending <= expected_q.size();
        end
    end

endmodule

### tb/volume_over_background_blend_unit_tb.sv
// ---------------------------------------------------------------------------
// volume_over_background_blend_unit_tb
// Drives pixels and register settings into the blend unit with random idle
// bursts on both channels; a checker beside the unit predicts and compares.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module volume_over_background_blend_unit_tb;
    import vobb_pkg::*;

    localparam int LIMIT_CYCLES  = 500000;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_PIXELS  = 50;
    localparam int LARGE_PIXELS  = 120;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [REG_W-1:0]     cfg_data;

    int mismatches;
    int pending;
    int checked;
    int blended;
    int cycles = 0;
    int src_idle_pct;
    int sink_idle_pct;
    int stall_left = 0;
    int settings = 0;

    vobb_pixel_if  pixel_ch ();
    vobb_result_if result_ch ();

    volume_over_background_blend_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pixel_ch),
        .result    (result_ch)
    );

    vobb_blend_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pixel      (pixel_ch),
        .result     (result_ch),
        .mismatches (mismatches),
        .pending    (pending),
        .checked    (checked),
        .blended    (blended)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results still pending", cycles, pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side back-pressure in random bursts
    always @(posedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            result_ch.ready <= 1'b0;
            stall_left--;
        end
        else if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct)
        begin
            result_ch.ready <= 1'b0;
            stall_left = $urandom_range(0, 2);
        end
        else
            result_ch.ready <= 1'b1;
    end

    // volume sample: zero, exactly 1.0, in range, or any 17-bit value
    function automatic logic [VOL_W-1:0] pick_sample();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return VOL_W'(65536);
            2:       return VOL_W'($urandom);
            default: return VOL_W'($urandom_range(0, 65536));
        endcase
    endfunction

    // screen size: mostly 1..12, sometimes 0 or 13..8191
    function automatic logic [REG_W-1:0] pick_dim();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return REG_W'($urandom_range(13, 8191));
            default: return REG_W'($urandom_range(1, 12));
        endcase
    endfunction

    // box bound near the screen size, sometimes any 13-bit value
    function automatic logic [REG_W-1:0] pick_bound(input logic [REG_W-1:0] span);
        if ($urandom_range(0, 7) == 0)
            return REG_W'($urandom);
        return REG_W'($urandom_range(0, int'(span) + 1));
    endfunction

    // one pixel transfer, with an optional idle burst in front
    task automatic send_pixel(input logic [BYTE_W-1:0] r, input logic [BYTE_W-1:0] g,
                              input logic [BYTE_W-1:0] b, input logic [VOL_W-1:0] vr,
                              input logic [VOL_W-1:0] vg, input logic [VOL_W-1:0] vb,
                              input logic [VOL_W-1:0] va);
        if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct)
        begin
            pixel_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        pixel_ch.valid     <= 1'b1;
        pixel_ch.bg_red    <= r;
        pixel_ch.bg_green  <= g;
        pixel_ch.bg_blue   <= b;
        pixel_ch.vol_red   <= vr;
        pixel_ch.vol_green <= vg;
        pixel_ch.vol_blue  <= vb;
        pixel_ch.vol_alpha <= va;
        @(posedge clk);
        while (!pixel_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_random_pixel();
        send_pixel(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                   pick_sample(), pick_sample(), pick_sample(), pick_sample());
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // stop sending, wait for every result, then load a full register set
    task automatic set_frame(input logic [REG_W-1:0] w, input logic [REG_W-1:0] h,
                             input logic [REG_W-1:0] x0, input logic [REG_W-1:0] x1,
                             input logic [REG_W-1:0] y0, input logic [REG_W-1:0] y1,
                             input logic [REG_W-1:0] pitch);
        pixel_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        write_reg(REG_UNUSED, REG_W'($urandom));
        write_reg(REG_SCREEN_WIDTH, w);
        write_reg(REG_SCREEN_HEIGHT, h);
        write_reg(REG_BOX_X_MIN, x0);
        write_reg(REG_BOX_X_MAX, x1);
        write_reg(REG_BOX_Y_MIN, y0);
        write_reg(REG_BOX_Y_MAX, y1);
        write_reg(REG_VOLUME_WIDTH, pitch);
        cfg_we <= 1'b0;
        settings++;
    endtask

    initial
    begin
        logic [REG_W-1:0] w;
        logic [REG_W-1:0] h;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = REG_SCREEN_WIDTH;
        cfg_data           = '0;
        pixel_ch.valid     = 1'b0;
        pixel_ch.bg_red    = '0;
        pixel_ch.bg_green  = '0;
        pixel_ch.bg_blue   = '0;
        pixel_ch.vol_red   = '0;
        pixel_ch.vol_green = '0;
        pixel_ch.vol_blue  = '0;
        pixel_ch.vol_alpha = '0;
        src_idle_pct       = 0;
        sink_idle_pct      = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: 1x1 screen, empty box, every pixel is a frame end
        send_pixel(8'd255, 8'd255, 8'd255, 17'd65536, 17'd65536, 17'd65536, 17'd65536);
        send_pixel(8'd0, 8'd0, 8'd0, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);

        // 4x2 screen, box covers columns 1..2 of both rows
        src_idle_pct  = 30;
        sink_idle_pct = 30;
        set_frame(13'd4, 13'd2, 13'd1, 13'd3, 13'd0, 13'd2, 13'd5);
        send_pixel(8'd12, 8'd200, 8'd77, 17'd65536, 17'd65536, 17'd65536, 17'd65536);
        send_pixel(8'd40, 8'd90, 8'd250, 17'd65536, 17'd65536, 17'd65536, 17'd0);
        send_pixel(8'd0, 8'd255, 8'd128, 17'd65536, 17'd0, 17'd32768, 17'd65536);
        send_pixel(8'd255, 8'd0, 8'd9, 17'd0, 17'd0, 17'd0, 17'd65536);
        send_pixel(8'd1, 8'd2, 8'd3, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
        // alpha above 1.0 drives the sum negative
        send_pixel(8'd255, 8'd255, 8'd255, 17'd0, 17'd0, 17'd0, 17'h1FFFF);
        // colour above 1.0 saturates
        send_pixel(8'd255, 8'd128, 8'd0, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'd1);
        send_pixel(8'd0, 8'd0, 8'd0, 17'd0, 17'd0, 17'd0, 17'd0);

        // inverted box: nothing is inside
        set_frame(13'd3, 13'd1, 13'd2, 13'd1, 13'd0, 13'd1, 13'd1);
        repeat (3)
            send_pixel(8'd200, 8'd100, 8'd50, 17'd65536, 17'd65536, 17'd65536, 17'd65536);

        // oversized width with zero height: one long row, box from column 100
        src_idle_pct  = 10;
        sink_idle_pct = 10;
        set_frame(13'd8191, 13'd0, 13'd100, 13'd4096, 13'd0, 13'd1, 13'd8191);
        repeat (LARGE_PIXELS)
            send_random_pixel();

        // zero width with oversized height: one pixel per row, tall column
        set_frame(13'd0, 13'd4097, 13'd0, 13'd1, 13'd0, 13'd4096, 13'd8191);
        repeat (LARGE_PIXELS)
            send_random_pixel();

        // random settings; sizes change with the counters mid-frame
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            w = pick_dim();
            h = pick_dim();
            if (p >= RANDOM_PHASES - 2)
            begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            else
            begin
                src_idle_pct  = 20 * $urandom_range(0, 2);
                sink_idle_pct = 20 * $urandom_range(0, 2);
            end
            set_frame(w, h, pick_bound(w), pick_bound(w), pick_bound(h), pick_bound(h),
                      ($urandom_range(0, 7) == 0) ? REG_W'($urandom)
                                                  : REG_W'($urandom_range(0, 16)));
            repeat (PHASE_PIXELS)
                send_random_pixel();
        end

        // drain, then allow for stray results
        pixel_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Checked %0d pixels (%0d blended in the box) over %0d register settings,",
                 checked, blended, settings);
        $display("incl. zero and oversized screen sizes, inverted box, alpha above 1.0.");
        if (mismatches == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
